// ===== hdl/sine_displacement_frame_warp_assert.svh =====
// ----------------------------------------------------------------------------
// Sine displacement frame warp assertion macros
// Short forms for the concurrent checks used by the warp modules. They
// expect signals named clock and reset in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SINE_DISPLACEMENT_FRAME_WARP_ASSERT_SVH
`define SINE_DISPLACEMENT_FRAME_WARP_ASSERT_SVH

// Same-cycle implication.
`define SDFW_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SDFW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sdfw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine displacement frame warp package
// Frame geometry, field widths, codes, word types and the ripple tables
// that are built at elaboration.
// ----------------------------------------------------------------------------
package sdfw_pkg;

   localparam int WIDTH  = 320;
   localparam int HEIGHT = 200;

   localparam int X_W        = $clog2(WIDTH);
   localparam int Y_W        = $clog2(HEIGHT);
   localparam int FRAME_SIZE = WIDTH * HEIGHT;
   localparam int ADDR_W     = $clog2(FRAME_SIZE);

   localparam int MODE_W       = 2;
   localparam int PIXEL_W      = 8;
   localparam int OUT_X_W      = 9;
   localparam int OUT_Y_W      = 8;
   localparam int PHASE_STEP_W = 8;
   localparam int GAIN_W       = 17;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 17;

   localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

   localparam int ROM_W      = 5;
   localparam int GAIN_SHIFT = 16;
   localparam int DISP_W     = 6;
   localparam int PROD_W     = ROM_W + GAIN_W + 1;
   localparam int CW         = ((X_W > Y_W) ? X_W : Y_W) + 2;

   localparam int PSUM_MAX = HEIGHT - 1 + (1 << PHASE_STEP_W) - 1;
   localparam int PSUM_W   = $clog2(PSUM_MAX + 1);

   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RENDER  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_STEP  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_LIMIT = 2'd2;

   localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RESET = 8'd2;
   localparam logic [GAIN_W-1:0]       GAIN_STEP_RESET  = 17'd3276;
   localparam logic [GAIN_W-1:0]       GAIN_LIMIT_RESET = 17'd85196;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PIXEL_W-1:0] pixel_in;
   } req_word_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic [OUT_X_W-1:0] out_x;
      logic [OUT_Y_W-1:0] out_y;
      logic               last_of_frame;
   } rsp_word_type;

   typedef struct packed {
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
      logic [X_W-1:0]    xx;
      logic [Y_W-1:0]    yy;
      logic [GAIN_W-1:0] gain;
      logic [ADDR_W-1:0] load_addr;
      logic              last;
   } seq_pos_type;

   // Angles are Q32 radians; PI_Q32 holds pi rounded to Q32.
   localparam logic [63:0] PI_Q32      = 64'd13493037705;
   localparam logic [63:0] TWO_PI_Q32  = 2 * PI_Q32;
   localparam logic [63:0] HALF_PI_Q32 = PI_Q32 / 2;
   localparam longint      SINE_ONE    = 64'sd1073741824;
   localparam logic [63:0] ROW_DEN     = 64'(10 * HEIGHT);
   localparam logic [63:0] COL_DEN     = 64'(10 * WIDTH);

   typedef logic signed [ROM_W-1:0] row_rom_type [HEIGHT];
   typedef logic signed [ROM_W-1:0] col_rom_type [WIDTH];
   typedef logic [X_W-1:0] shift_rom_type [HEIGHT];

   // Truncated Taylor series of the sine, scaled by ten and truncated.
   function automatic logic signed [ROM_W-1:0] ripple_sine(input logic [63:0] theta);
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      logic        neg;
      r   = theta % TWO_PI_Q32;
      neg = 1'b0;
      if (r >= PI_Q32) begin
         r   = r - PI_Q32;
         neg = 1'b1;
      end
      if (r > HALF_PI_Q32) begin
         r = PI_Q32 - r;
      end
      x    = r >> 2;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > SINE_ONE) begin
         sum = SINE_ONE;
      end
      v = (unsigned'(sum) * 64'd10) >> 30;
      return neg ? ROM_W'(-v) : ROM_W'(v);
   endfunction

   function automatic logic [63:0] row_theta(input int unsigned i);
      return ((64'(i) * 64'd314) << 32) / ROW_DEN;
   endfunction

   function automatic logic [63:0] col_theta(input int unsigned i);
      return ((64'(i) * 64'd314) << 32) / COL_DEN;
   endfunction

   function automatic row_rom_type build_row_rom();
      row_rom_type t;
      for (int i = 0; i < HEIGHT; i++) begin
         t[i] = ripple_sine(row_theta(i));
      end
      return t;
   endfunction

   function automatic col_rom_type build_col_rom();
      col_rom_type t;
      for (int i = 0; i < WIDTH; i++) begin
         t[i] = ripple_sine(col_theta(i));
      end
      return t;
   endfunction

   // Column shift for each ripple phase, phase * WIDTH / HEIGHT.
   function automatic shift_rom_type build_shift_rom();
      shift_rom_type t;
      for (int i = 0; i < HEIGHT; i++) begin
         t[i] = X_W'((i * WIDTH) / HEIGHT);
      end
      return t;
   endfunction

   localparam row_rom_type   ROW_ROM         = build_row_rom();
   localparam col_rom_type   COL_ROM         = build_col_rom();
   localparam shift_rom_type PHASE_SHIFT_ROM = build_shift_rom();

endpackage

// ===== hdl/sdfw_frame_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine displacement frame warp source frame memory
// Single-port frame store with one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module sdfw_frame_ram
   import sdfw_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  addr,
   input  logic [PIXEL_W-1:0] wr_data,
   output logic [PIXEL_W-1:0] rd_data
);

   logic [PIXEL_W-1:0] frame_mem [FRAME_SIZE];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sdfw_frame_seq.sv =====
`timescale 1ns / 1ps
`include "sine_displacement_frame_warp_assert.svh"
// ----------------------------------------------------------------------------
// Sine displacement frame warp sequencer
// Holds the load and render positions, the ripple phase and gain and the
// control registers, and steps the phase, its column shift and the gain at frame end.
// ----------------------------------------------------------------------------
module sdfw_frame_seq
   import sdfw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   item_accept,
   input  logic [MODE_W-1:0]      item_mode,
   output seq_pos_type            pos
);

   logic [Y_W-1:0]           phase_ff, phase_in;
   logic [X_W-1:0]           shift_ff, shift_in;
   logic [X_W-1:0]           x_ff, x_in;
   logic [Y_W-1:0]           y_ff, y_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic [ADDR_W-1:0]        load_ff, load_in;
   logic [PHASE_STEP_W-1:0]  phase_step_ff, phase_step_in;
   logic [GAIN_W-1:0]        gain_step_ff, gain_step_in;
   logic [GAIN_W-1:0]        gain_limit_ff, gain_limit_in;

   logic [PSUM_W-1:0] phase_sum;
   logic [PSUM_W-1:0] phase_once;
   logic [PSUM_W-1:0] phase_twice;
   logic [Y_W-1:0]    phase_next;
   logic [Y_W:0]      yy_sum;
   logic [X_W:0]      xx_sum;
   logic [GAIN_W:0]   gain_sum;
   logic              last;
   logic              frame_end;

   assign phase_sum   = PSUM_W'(phase_ff) + PSUM_W'(phase_step_ff);
   assign phase_once  = (phase_sum >= PSUM_W'(HEIGHT)) ? phase_sum - PSUM_W'(HEIGHT)
                                                       : phase_sum;
   assign phase_twice = (phase_once >= PSUM_W'(HEIGHT)) ? phase_once - PSUM_W'(HEIGHT)
                                                        : phase_once;
   assign phase_next  = Y_W'(phase_twice);

   assign yy_sum    = {1'b0, y_ff} + {1'b0, phase_ff};
   assign xx_sum    = {1'b0, x_ff} + {1'b0, shift_ff};
   assign gain_sum  = {1'b0, gain_ff} + {1'b0, gain_step_ff};
   assign last      = (x_ff == X_W'(WIDTH - 1)) && (y_ff == Y_W'(HEIGHT - 1));
   assign frame_end = item_accept && (item_mode == MODE_RENDER) && last;

   always_comb begin
      pos.x         = x_ff;
      pos.y         = y_ff;
      pos.yy        = (yy_sum >= (Y_W + 1)'(HEIGHT)) ? Y_W'(yy_sum - (Y_W + 1)'(HEIGHT))
                                                     : Y_W'(yy_sum);
      pos.xx        = (xx_sum >= (X_W + 1)'(WIDTH)) ? X_W'(xx_sum - (X_W + 1)'(WIDTH))
                                                    : X_W'(xx_sum);
      pos.gain      = gain_ff;
      pos.load_addr = load_ff;
      pos.last      = last;
   end

   always_comb begin
      phase_in      = phase_ff;
      shift_in      = shift_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      gain_in       = gain_ff;
      load_in       = load_ff;
      phase_step_in = phase_step_ff;
      gain_step_in  = gain_step_ff;
      gain_limit_in = gain_limit_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PHASE_STEP: phase_step_in = csr_wdata[PHASE_STEP_W-1:0];
            CSR_GAIN_STEP:  gain_step_in  = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_LIMIT: gain_limit_in = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end

      if (item_accept) begin
         unique case (item_mode)
            MODE_LOAD: begin
               load_in = (load_ff == ADDR_W'(FRAME_SIZE - 1)) ? '0 : load_ff + 1'b1;
            end
            MODE_RENDER: begin
               if (last) begin
                  x_in     = '0;
                  y_in     = '0;
                  phase_in = phase_next;
                  shift_in = PHASE_SHIFT_ROM[phase_next];
                  if (gain_ff < gain_limit_ff) begin
                     gain_in = gain_sum[GAIN_W] ? GAIN_MAX : gain_sum[GAIN_W-1:0];
                  end
               end else if (x_ff == X_W'(WIDTH - 1)) begin
                  x_in = '0;
                  y_in = y_ff + 1'b1;
               end else begin
                  x_in = x_ff + 1'b1;
               end
            end
            MODE_RESTART: begin
               gain_in = '0;
               load_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         shift_ff      <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         gain_ff       <= '0;
         load_ff       <= '0;
         phase_step_ff <= PHASE_STEP_RESET;
         gain_step_ff  <= GAIN_STEP_RESET;
         gain_limit_ff <= GAIN_LIMIT_RESET;
      end else begin
         phase_ff      <= phase_in;
         shift_ff      <= shift_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         gain_ff       <= gain_in;
         load_ff       <= load_in;
         phase_step_ff <= phase_step_in;
         gain_step_ff  <= gain_step_in;
         gain_limit_ff <= gain_limit_in;
      end
   end

   `SDFW_ASSERT_NEXT(a_last_wraps, frame_end, x_ff == '0 && y_ff == '0, "scan did not wrap")
   `SDFW_ASSERT_IMPLY(a_phase_range, 1'b1, (Y_W + 1)'(phase_ff) < (Y_W + 1)'(HEIGHT), "bad phase")
   `SDFW_ASSERT_IMPLY(a_shift_tracks, 1'b1, shift_ff == PHASE_SHIFT_ROM[phase_ff], "shift off phase")

endmodule

// ===== hdl/sine_displacement_frame_warp.sv =====
`timescale 1ns / 1ps
`include "sine_displacement_frame_warp_assert.svh"
// ----------------------------------------------------------------------------
// Sine displacement frame warp
// Stores one 8-bit frame loaded in raster order and streams it back warped
// by a sine ripple whose phase and strength change from frame to frame.
//
// Request words carry a mode and a pixel: a load word writes the next source
// pixel, a render word asks for the next output pixel, a restart word clears
// the gain and the load position. Only render words give a response word,
// with the pixel, its column and row, and a flag on the last pixel of a frame.
// Both channels move a word at a clock edge where valid is high and stall is
// low. Control registers must be written through the csr port while idle;
// the block does not enforce it. One word is taken every cycle while the
// request side is not stalled, also at a frame end, where the new phase and
// its column shift are settled in the same cycle. A render word's response
// leaves the last of the four pipeline stages. When the response side stalls,
// the stages keep filling and the request side stalls only once all are full.
// Reset clears the positions, phase and gain and loads the register
// defaults; the frame memory holds unknown data until it is loaded.
// ----------------------------------------------------------------------------
module sine_displacement_frame_warp
   import sdfw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   function automatic logic signed [CW-1:0] wrap_coord(input logic signed [CW-1:0] v,
                                                       input logic signed [CW-1:0] size);
      logic signed [CW-1:0] t;
      t = v;
      if (t < 0) begin
         t = t + size;
      end
      if (t < 0) begin
         t = t + size;
      end
      if (t >= size) begin
         t = t - size;
      end
      if (t >= size) begin
         t = t - size;
      end
      return t;
   endfunction

   seq_pos_type pos;
   logic        accept;
   logic        go1;
   logic        rdy1, rdy2, rdy3, rdy4;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;

   logic                    load1_ff;
   logic [PIXEL_W-1:0]      pix1_ff;
   logic [ADDR_W-1:0]       addr1_ff;
   logic [X_W-1:0]          x1_ff;
   logic [Y_W-1:0]          y1_ff;
   logic                    last1_ff;
   logic [GAIN_W-1:0]       gain1_ff;
   logic signed [ROM_W-1:0] rrom1_ff;
   logic signed [ROM_W-1:0] crom1_ff;

   logic                     load2_ff;
   logic [PIXEL_W-1:0]       pix2_ff;
   logic [ADDR_W-1:0]        addr2_ff;
   logic [X_W-1:0]           x2_ff;
   logic [Y_W-1:0]           y2_ff;
   logic                     last2_ff;
   logic signed [DISP_W-1:0] dx2_ff;
   logic signed [DISP_W-1:0] dy2_ff;

   logic               load3_ff;
   logic [PIXEL_W-1:0] pix3_ff;
   logic [ADDR_W-1:0]  addr3_ff;
   logic [X_W-1:0]     x3_ff;
   logic [Y_W-1:0]     y3_ff;
   logic               last3_ff;
   logic [X_W-1:0]     xt3_ff;
   logic [Y_W-1:0]     yt3_ff;

   logic [X_W-1:0] x4_ff;
   logic [Y_W-1:0] y4_ff;
   logic           last4_ff;

   logic signed [PROD_W-1:0] prod_x;
   logic signed [PROD_W-1:0] prod_y;
   logic signed [CW-1:0]     xs;
   logic signed [CW-1:0]     ys;
   logic signed [CW-1:0]     xw;
   logic signed [CW-1:0]     yw;
   logic [ADDR_W-1:0]        render_addr;
   logic [ADDR_W-1:0]        ram_addr;
   logic                     ram_wr_en;
   logic                     ram_rd_en;
   logic [PIXEL_W-1:0]       ram_rd_data;

   sdfw_frame_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .item_accept  (accept),
      .item_mode    (req_word.mode),
      .pos          (pos)
   );

   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall = !rdy1;
   assign accept    = req_valid && !req_stall;
   assign go1       = accept && (req_word.mode == MODE_LOAD || req_word.mode == MODE_RENDER);

   assign v1_in = rdy1 ? go1 : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? (v3_ff && !load3_ff) : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign prod_x = PROD_W'(rrom1_ff) * PROD_W'($signed({1'b0, gain1_ff}));
   assign prod_y = PROD_W'(crom1_ff) * PROD_W'($signed({1'b0, gain1_ff}));

   assign xs = $signed({{(CW - X_W){1'b0}}, x2_ff})
             + $signed({{(CW - DISP_W){dx2_ff[DISP_W-1]}}, dx2_ff});
   assign ys = $signed({{(CW - Y_W){1'b0}}, y2_ff})
             + $signed({{(CW - DISP_W){dy2_ff[DISP_W-1]}}, dy2_ff});
   assign xw = wrap_coord(xs, CW'(WIDTH));
   assign yw = wrap_coord(ys, CW'(HEIGHT));

   always_ff @(posedge clock) begin
      if (rdy1) begin
         load1_ff <= (req_word.mode == MODE_LOAD);
         pix1_ff  <= req_word.pixel_in;
         addr1_ff <= pos.load_addr;
         x1_ff    <= pos.x;
         y1_ff    <= pos.y;
         last1_ff <= pos.last;
         gain1_ff <= pos.gain;
         rrom1_ff <= ROW_ROM[pos.yy];
         crom1_ff <= COL_ROM[pos.xx];
      end
      if (rdy2) begin
         load2_ff <= load1_ff;
         pix2_ff  <= pix1_ff;
         addr2_ff <= addr1_ff;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         last2_ff <= last1_ff;
         dx2_ff   <= prod_x[GAIN_SHIFT +: DISP_W];
         dy2_ff   <= prod_y[GAIN_SHIFT +: DISP_W];
      end
      if (rdy3) begin
         load3_ff <= load2_ff;
         pix3_ff  <= pix2_ff;
         addr3_ff <= addr2_ff;
         x3_ff    <= x2_ff;
         y3_ff    <= y2_ff;
         last3_ff <= last2_ff;
         xt3_ff   <= X_W'(xw);
         yt3_ff   <= Y_W'(yw);
      end
      if (rdy4) begin
         x4_ff    <= x3_ff;
         y4_ff    <= y3_ff;
         last4_ff <= last3_ff;
      end
   end

   assign render_addr = ADDR_W'(yt3_ff) * ADDR_W'(WIDTH) + ADDR_W'(xt3_ff);
   assign ram_addr    = load3_ff ? addr3_ff : render_addr;
   assign ram_wr_en   = v3_ff && rdy4 && load3_ff;
   assign ram_rd_en   = v3_ff && rdy4 && !load3_ff;

   sdfw_frame_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (pix3_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = v4_ff;

   always_comb begin
      rsp_word.pixel_out     = ram_rd_data;
      rsp_word.out_x         = OUT_X_W'(x4_ff);
      rsp_word.out_y         = OUT_Y_W'(y4_ff);
      rsp_word.last_of_frame = last4_ff;
   end

   `SDFW_ASSERT_NEXT(a_load_no_result, v3_ff && load3_ff && rdy4, !v4_ff, "load word produced a response")
   `SDFW_ASSERT_NEXT(a_render_reaches_out, v3_ff && !load3_ff && rdy4, v4_ff, "render word lost before output")
   `SDFW_ASSERT_IMPLY(a_last_position, v4_ff && last4_ff, x4_ff == X_W'(WIDTH - 1) && y4_ff == Y_W'(HEIGHT - 1), "frame end flag away from last pixel")

endmodule

// ===== test/tb_sine_displacement_frame_warp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine displacement frame warp testbench
// Loads source pixels and renders output pixels under changing register
// settings, with random idling on both channels. A scoreboard predicts each
// warped pixel, its position and the end-of-frame flag, and checks every
// response word in order.
// ----------------------------------------------------------------------------
module tb_sine_displacement_frame_warp;
   import sdfw_pkg::*;

   localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
   localparam int unsigned CYCLE_LIMIT   = 200_000;
   localparam int unsigned MIXED_ITEMS   = 720;
   localparam int unsigned TAIL_ITEMS    = 110;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned SETTLE_CYCLES = 80;

   class warp_predictor;
      int row_ripple [HEIGHT];
      int col_ripple [WIDTH];
      logic [PIXEL_W-1:0] frame_px [FRAME_SIZE];
      bit written [FRAME_SIZE];
      logic [X_W-1:0] column;
      logic [Y_W-1:0] row;
      logic [Y_W-1:0] phase;
      logic [GAIN_W-1:0] gain;
      logic [ADDR_W-1:0] load_at;
      logic [PHASE_STEP_W-1:0] phase_step;
      logic [GAIN_W-1:0] gain_step;
      logic [GAIN_W-1:0] gain_limit;
      int unsigned mismatches;
      rsp_word_type expected_pixels[$];

      function new();
         int i;
         for (i = 0; i < HEIGHT; i++) begin
            row_ripple[i] = sine_tenths(i, HEIGHT);
         end
         for (i = 0; i < WIDTH; i++) begin
            col_ripple[i] = sine_tenths(i, WIDTH);
         end
         column = '0;
         row = '0;
         phase = '0;
         gain = '0;
         load_at = '0;
         phase_step = PHASE_STEP_RESET;
         gain_step = GAIN_STEP_RESET;
         gain_limit = GAIN_LIMIT_RESET;
         mismatches = 0;
      endfunction

      // Ten times the sine of i*31.4/n, from a truncated Taylor series in Q30.
      function int sine_tenths(int unsigned i, int unsigned n);
         logic [63:0] angle;
         logic [63:0] x;
         logic [63:0] x2;
         logic [63:0] term;
         longint acc;
         bit negative;
         int k;
         int v;
         angle = ((64'(i) * 64'd314) << 32) / (64'd10 * 64'(n));
         angle = angle % (64'd2 * PI_Q32);
         negative = (angle >= PI_Q32);
         if (negative) begin
            angle = angle - PI_Q32;
         end
         if (angle > PI_Q32 / 64'd2) begin
            angle = PI_Q32 - angle;
         end
         x = angle >> 2;
         x2 = (x * x) >> 30;
         term = x;
         acc = longint'(x);
         for (k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / 64'(4 * k * k + 2 * k);
            acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
         end
         if (acc < 0) begin
            acc = 0;
         end
         if (acc > (longint'(1) << 30)) begin
            acc = longint'(1) << 30;
         end
         v = int'((acc * 10) >>> 30);
         return negative ? -v : v;
      endfunction

      function int displaced(int ripple);
         longint p;
         p = longint'(ripple) * longint'(gain);
         return int'(p >>> 16);
      endfunction

      function int unsigned source_index();
         int yy;
         int xx;
         int xs;
         int ys;
         yy = (int'(row) + int'(phase)) % HEIGHT;
         xx = (int'(column) + int'(phase) * WIDTH / HEIGHT) % WIDTH;
         xs = (int'(column) + displaced(row_ripple[yy]) + WIDTH) % WIDTH;
         ys = (int'(row) + displaced(col_ripple[xx]) + HEIGHT) % HEIGHT;
         return ys * WIDTH + xs;
      endfunction

      function bit render_reads_unwritten();
         return !written[source_index()];
      endfunction

      function int unsigned waiting();
         return expected_pixels.size();
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_PHASE_STEP: phase_step = value[PHASE_STEP_W-1:0];
            CSR_GAIN_STEP: gain_step = value[GAIN_W-1:0];
            CSR_GAIN_LIMIT: gain_limit = value[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type px;
         int unsigned at;
         logic [GAIN_W:0] grown;
         case (w.mode)
            MODE_LOAD: begin
               frame_px[load_at] = w.pixel_in;
               written[load_at] = 1'b1;
               load_at = (int'(load_at) == FRAME_SIZE - 1) ? '0 : load_at + 1'b1;
            end
            MODE_RESTART: begin
               gain = '0;
               load_at = '0;
            end
            MODE_RENDER: begin
               at = source_index();
               px.pixel_out = frame_px[at];
               px.out_x = OUT_X_W'(column);
               px.out_y = OUT_Y_W'(row);
               px.last_of_frame = (int'(column) == WIDTH - 1) && (int'(row) == HEIGHT - 1);
               expected_pixels.push_back(px);
               if (px.last_of_frame) begin
                  column = '0;
                  row = '0;
                  phase = Y_W'((int'(phase) + int'(phase_step)) % HEIGHT);
                  if (gain < gain_limit) begin
                     grown = gain + gain_step;
                     gain = (grown > GAIN_MAX) ? GAIN_MAX : grown[GAIN_W-1:0];
                  end
               end else if (int'(column) == WIDTH - 1) begin
                  column = '0;
                  row = row + 1'b1;
               end else begin
                  column = column + 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_pixel(rsp_word_type got);
         rsp_word_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: response word expected none, got %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("pixel_out", want.pixel_out, got.pixel_out);
         compare_field("out_x", want.out_x, got.out_x);
         compare_field("out_y", want.out_y, got.out_y);
         compare_field("last_of_frame", want.last_of_frame, got.last_of_frame);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   rsp_word_type rsp_word;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bit response_gaps = 1'b0;
   bit hold_request = 1'b0;
   int unsigned cycle_count = 0;
   warp_predictor warp = new();

   sine_displacement_frame_warp dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sine_displacement_frame_warp] ERROR");
         $finish;
      end
   end

   initial begin : response_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            warp.check_pixel(rsp_word);
         end
         if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) begin
               rsp_stall <= 1'b0;
            end
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if (response_gaps && $urandom_range(0, 23) == 0) begin
            stall_left = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [PIXEL_W-1:0] pixel,
                            input bit gaps);
      req_word_type w;
      w.mode = mode;
      w.pixel_in = pixel;
      if (gaps && $urandom_range(0, 23) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      warp.note_request(w);
   endtask

   task automatic wait_drained(input int unsigned quiet_cycles);
      req_valid <= 1'b0;
      do @(posedge clock); while (warp.waiting() != 0);
      repeat (quiet_cycles) @(posedge clock);
   endtask

   task automatic program_registers(input logic [PHASE_STEP_W-1:0] phase_rows,
                                    input logic [GAIN_W-1:0] gain_inc,
                                    input logic [GAIN_W-1:0] gain_cap);
      csr_write_en <= 1'b1;
      csr_index <= CSR_PHASE_STEP;
      csr_wdata <= CSR_DATA_W'(phase_rows);
      @(posedge clock);
      warp.set_register(CSR_PHASE_STEP, CSR_DATA_W'(phase_rows));
      csr_index <= CSR_GAIN_STEP;
      csr_wdata <= gain_inc;
      @(posedge clock);
      warp.set_register(CSR_GAIN_STEP, gain_inc);
      csr_index <= CSR_GAIN_LIMIT;
      csr_wdata <= gain_cap;
      @(posedge clock);
      warp.set_register(CSR_GAIN_LIMIT, gain_cap);
      csr_write_en <= 1'b0;
   endtask

   // A render that would read a pixel never loaded becomes a load instead.
   function automatic logic [MODE_W-1:0] pick_mode(int unsigned load_pct,
                                                   int unsigned render_pct,
                                                   int unsigned restart_pct);
      int unsigned roll;
      logic [MODE_W-1:0] mode;
      roll = $urandom_range(0, 99);
      if (roll < load_pct) begin
         mode = MODE_LOAD;
      end else if (roll < load_pct + render_pct) begin
         mode = MODE_RENDER;
      end else if (roll < load_pct + render_pct + restart_pct) begin
         mode = MODE_RESTART;
      end else begin
         mode = MODE_NONE;
      end
      if (mode == MODE_RENDER && warp.render_reads_unwritten()) begin
         mode = MODE_LOAD;
      end
      return mode;
   endfunction

   initial begin : stimulus
      int unsigned counted;
      logic [GAIN_W-1:0] late_step;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_PHASE_STEP;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(MODE_LOAD, 8'h00, 1'b0);
      send_item(MODE_LOAD, 8'hFF, 1'b0);
      send_item(MODE_LOAD, 8'h80, 1'b0);
      send_item(MODE_LOAD, 8'h7F, 1'b0);
      send_item(MODE_LOAD, 8'h01, 1'b0);
      send_item(MODE_LOAD, 8'hFE, 1'b0);
      send_item(MODE_RENDER, 8'hFF, 1'b0);
      send_item(MODE_NONE, 8'hA5, 1'b0);
      send_item(MODE_RENDER, 8'h00, 1'b0);
      send_item(MODE_RENDER, 8'h5A, 1'b0);
      send_item(MODE_RESTART, 8'hC3, 1'b0);
      send_item(MODE_LOAD, 8'h33, 1'b0);
      send_item(MODE_LOAD, 8'hCC, 1'b0);
      send_item(MODE_RENDER, 8'h3C, 1'b0);
      send_item(MODE_RENDER, 8'hFF, 1'b0);
      send_item(MODE_RENDER, 8'h00, 1'b0);
      send_item(MODE_NONE, 8'hFF, 1'b0);
      send_item(MODE_RESTART, 8'h00, 1'b0);

      response_gaps = 1'b1;
      counted = 0;
      while (counted < MIXED_ITEMS) begin
         send_item(pick_mode(50, 40, 2), PIXEL_W'($urandom), 1'b1);
         counted++;
         if (counted == 300) begin
            hold_request = 1'b1;
         end
         if (counted == 500) begin
            wait_drained(SETTLE_CYCLES);
            late_step = GAIN_W'($urandom_range(1, 65535));
            program_registers(PHASE_STEP_W'($urandom_range(0, 199)), late_step,
                              GAIN_W'($urandom_range(int'(late_step) + 1, int'(GAIN_MAX))));
         end
      end

      response_gaps = 1'b0;
      counted = 0;
      while (counted < TAIL_ITEMS) begin
         send_item(pick_mode(40, 55, 1), PIXEL_W'($urandom), 1'b0);
         counted++;
      end
      wait_drained(100);

      if (warp.mismatches == 0 && warp.waiting() == 0) begin
         $display("[sine_displacement_frame_warp] OK");
      end else begin
         $display("[sine_displacement_frame_warp] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sdfw_pkg.sv
hdl/sdfw_frame_ram.sv
hdl/sdfw_frame_seq.sv
hdl/sine_displacement_frame_warp.sv
test/tb_sine_displacement_frame_warp.sv
